// File: rtl/polynomial_eval_with_derivative_unit_macros.svh
// Assertion macros for the polynomial evaluator.
// Included by modules that check their own sequencing; needs clk and rst_n in scope.
`ifndef POLYNOMIAL_EVAL_WITH_DERIVATIVE_UNIT_MACROS_SVH
`define POLYNOMIAL_EVAL_WITH_DERIVATIVE_UNIT_MACROS_SVH

`ifndef SYNTH
`define PEV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pev check failed");
`define PEV_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pev check failed");
`else
`define PEV_ASSERT_IMP(lbl, pre, post)
`define PEV_ASSERT_NXT(lbl, pre, post)
`endif

`endif

// File: rtl/pev_pkg.sv
// Shared types, constants, microcode and saturating arithmetic helpers
// for the polynomial evaluator. No dependencies.
package pev_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int DEG_W     = 3;
  localparam int REG_IDX_W = 3;
  localparam int STEP_W    = 3;
  localparam int WIDE_W    = 64;

  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN   = 32'sh8000_0000;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INIT,
    OP_MUL,
    OP_ADD,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_IDX_ZERO,
    COND_IDX_NZ,
    COND_OUT_BUSY
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    step_t  jump;
    step_t  next;
  } uword_t;

  typedef struct packed {
    logic req;
    logic idx_zero;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } sat_res_t;

  localparam step_t ST_WAIT = 3'd0;
  localparam step_t ST_INIT = 3'd1;
  localparam step_t ST_MUL  = 3'd2;
  localparam step_t ST_ADD  = 3'd3;
  localparam step_t ST_EMIT = 3'd4;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      ST_WAIT: w = '{op: OP_LOAD, cond: COND_NO_REQ,   jump: ST_WAIT, next: ST_INIT};
      ST_INIT: w = '{op: OP_INIT, cond: COND_IDX_ZERO, jump: ST_EMIT, next: ST_MUL};
      ST_MUL:  w = '{op: OP_MUL,  cond: COND_NEVER,    jump: ST_WAIT, next: ST_ADD};
      ST_ADD:  w = '{op: OP_ADD,  cond: COND_IDX_NZ,   jump: ST_MUL,  next: ST_EMIT};
      ST_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_BUSY, jump: ST_EMIT, next: ST_WAIT};
      default: w = '{op: OP_LOAD, cond: COND_NO_REQ,   jump: ST_WAIT, next: ST_INIT};
    endcase
    return w;
  endfunction

  function automatic sat_res_t sat_wide(input logic signed [WIDE_W-1:0] v);
    sat_res_t r;
    if (v > S32_MAX_W) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else if (v < S32_MIN_W) begin
      r.val = S32_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_res_t mul_q16(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
    logic signed [WIDE_W-1:0] p;
    p = a * b;
    return sat_wide(p >>> FRAC_W);
  endfunction

  function automatic sat_res_t add_sat(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
    logic signed [WIDE_W-1:0] s;
    s = WIDE_W'(a) + WIDE_W'(b);
    return sat_wide(s);
  endfunction

endpackage

// File: rtl/pev_if.sv
// Request channel interfaces for the polynomial evaluator.
// Depends on pev_pkg for field widths.
interface pev_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pev_pkg::DATA_W-1:0] point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

interface pev_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pev_pkg::DATA_W-1:0] value;
  logic signed [pev_pkg::DATA_W-1:0] slope;
  logic        [pev_pkg::DEG_W-1:0]  poly_degree;
  logic                              value_saturated;
  logic                              slope_saturated;

  modport source (output valid, output value, output slope, output poly_degree,
                  output value_saturated, output slope_saturated, input ready);
  modport sink   (input valid, input value, input slope, input poly_degree,
                  input value_saturated, input slope_saturated, output ready);
endinterface

// File: rtl/pev_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on pev_pkg and the assertion macro header.
`include "polynomial_eval_with_derivative_unit_macros.svh"

module pev_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  pev_pkg::dp_status_t sts,
  output pev_pkg::uword_t     ctrl
);

  pev_pkg::step_t step_r;
  pev_pkg::step_t step_nxt;
  logic           take;

  assign ctrl = pev_pkg::ucode(step_r);

  always_comb begin
    unique case (ctrl.cond)
      pev_pkg::COND_NEVER:    take = 1'b0;
      pev_pkg::COND_NO_REQ:   take = !sts.req;
      pev_pkg::COND_IDX_ZERO: take = sts.idx_zero;
      pev_pkg::COND_IDX_NZ:   take = !sts.idx_zero;
      pev_pkg::COND_OUT_BUSY: take = sts.out_busy;
      default:                take = 1'b0;
    endcase
    step_nxt = take ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pev_pkg::ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  `PEV_ASSERT_NXT(a_accept_inits, ctrl.op == pev_pkg::OP_LOAD && sts.req, ctrl.op == pev_pkg::OP_INIT)
  `PEV_ASSERT_NXT(a_mul_then_add, ctrl.op == pev_pkg::OP_MUL, ctrl.op == pev_pkg::OP_ADD)
  `PEV_ASSERT_NXT(a_emit_returns, ctrl.op == pev_pkg::OP_EMIT && !sts.out_busy, ctrl.op == pev_pkg::OP_LOAD)

endmodule

// File: rtl/pev_dp.sv
// Datapath: coefficient registers, degree detect, shared multiplier pair,
// saturating adders and output register. Depends on pev_pkg, pev_if, macro header.
`include "polynomial_eval_with_derivative_unit_macros.svh"

module pev_dp #(
  parameter int NUM_COEFFS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pev_pkg::uword_t                     ctrl,
  output pev_pkg::dp_status_t                 sts,
  input  logic                                cfg_we,
  input  logic [pev_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [pev_pkg::DATA_W-1:0]          cfg_data,
  pev_in_if.sink                              in_chan,
  pev_out_if.source                           out_chan
);

  localparam int CW = $clog2(NUM_COEFFS);

  logic signed [pev_pkg::DATA_W-1:0] coef_r [NUM_COEFFS];
  logic signed [pev_pkg::DATA_W-1:0] x_r;
  logic signed [pev_pkg::DATA_W-1:0] acc_v_r;
  logic signed [pev_pkg::DATA_W-1:0] acc_s_r;
  logic signed [pev_pkg::DATA_W-1:0] dc_r;
  logic        [CW-1:0]              deg_r;
  logic        [CW-1:0]              idx_r;
  logic                              vsat_r;
  logic                              ssat_r;
  logic                              out_valid_r;
  logic signed [pev_pkg::DATA_W-1:0] out_value_r;
  logic signed [pev_pkg::DATA_W-1:0] out_slope_r;
  logic        [pev_pkg::DEG_W-1:0]  out_deg_r;
  logic                              out_vsat_r;
  logic                              out_ssat_r;

  logic        [CW-1:0]              deg_det;
  logic        [CW-1:0]              idx_dec;
  logic        [CW-1:0]              rd_idx;
  logic signed [pev_pkg::DATA_W-1:0] coef_rd;
  logic signed [pev_pkg::DEG_W:0]    scale_s;
  logic signed [pev_pkg::WIDE_W-1:0] scaled_w;
  pev_pkg::sat_res_t                 scaled;
  pev_pkg::sat_res_t                 mv;
  pev_pkg::sat_res_t                 ms;
  pev_pkg::sat_res_t                 sv;
  pev_pkg::sat_res_t                 ss;
  logic                              cfg_hit;
  logic                              req;
  logic                              out_busy;
  logic                              emit;

  always_comb begin
    deg_det = '0;
    for (int i = 0; i < NUM_COEFFS; i++) begin
      if (coef_r[i] != '0) begin
        deg_det = CW'(i);
      end
    end
  end

  assign idx_dec  = idx_r - 1'b1;
  assign rd_idx   = (ctrl.op == pev_pkg::OP_MUL) ? idx_dec : idx_r;
  assign coef_rd  = coef_r[rd_idx];
  assign scale_s  = signed'({1'b0, pev_pkg::DEG_W'(rd_idx)});
  assign scaled_w = scale_s * coef_rd;
  assign scaled   = pev_pkg::sat_wide(scaled_w);
  assign mv       = pev_pkg::mul_q16(acc_v_r, x_r);
  assign ms       = pev_pkg::mul_q16(acc_s_r, x_r);
  assign sv       = pev_pkg::add_sat(acc_v_r, coef_rd);
  assign ss       = pev_pkg::add_sat(acc_s_r, dc_r);

  assign cfg_hit  = cfg_we && (32'(cfg_index) < NUM_COEFFS);
  assign req      = in_chan.valid && in_chan.ready;
  assign out_busy = out_valid_r && !out_chan.ready;
  assign emit     = (ctrl.op == pev_pkg::OP_EMIT) && !out_busy;

  assign in_chan.ready = (ctrl.op == pev_pkg::OP_LOAD);
  assign sts = '{req: req, idx_zero: (idx_r == '0), out_busy: out_busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        coef_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        coef_r[cfg_index[CW-1:0]] <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      pev_pkg::OP_LOAD: begin
        if (req) begin
          x_r   <= in_chan.point;
          deg_r <= deg_det;
          idx_r <= deg_det;
        end
      end
      pev_pkg::OP_INIT: begin
        acc_v_r <= coef_rd;
        acc_s_r <= scaled.val;
        vsat_r  <= 1'b0;
        ssat_r  <= scaled.sat;
      end
      pev_pkg::OP_MUL: begin
        idx_r   <= idx_dec;
        acc_v_r <= mv.val;
        vsat_r  <= vsat_r | mv.sat;
        if (idx_dec != '0) begin
          acc_s_r <= ms.val;
          dc_r    <= scaled.val;
          ssat_r  <= ssat_r | ms.sat | scaled.sat;
        end
      end
      pev_pkg::OP_ADD: begin
        acc_v_r <= sv.val;
        vsat_r  <= vsat_r | sv.sat;
        if (idx_r != '0) begin
          acc_s_r <= ss.val;
          ssat_r  <= ssat_r | ss.sat;
        end
      end
      pev_pkg::OP_EMIT: begin
        if (emit) begin
          out_value_r <= acc_v_r;
          out_slope_r <= acc_s_r;
          out_deg_r   <= pev_pkg::DEG_W'(deg_r);
          out_vsat_r  <= vsat_r;
          out_ssat_r  <= ssat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.value           = out_value_r;
  assign out_chan.slope           = out_slope_r;
  assign out_chan.poly_degree     = out_deg_r;
  assign out_chan.value_saturated = out_vsat_r;
  assign out_chan.slope_saturated = out_ssat_r;

  `PEV_ASSERT_NXT(a_idx_steps_down, ctrl.op == pev_pkg::OP_MUL, idx_r == CW'($past(idx_r) - 1'b1))
  `PEV_ASSERT_IMP(a_mul_needs_idx, ctrl.op == pev_pkg::OP_MUL, idx_r != '0)

endmodule

// File: rtl/polynomial_eval_with_derivative_unit.sv
// Polynomial evaluator with first derivative, Horner's rule in signed Q16.16.
// Depends on pev_pkg, pev_if, pev_seq and pev_dp.
//
// Usage:
//   cfg_we/cfg_index/cfg_data write coefficient register cfg_index (constant
//   term at index 0). Registers at NUM_COEFFS or above are dropped. Write
//   only while the block is idle.
//   in_chan carries one request: the point x. out_chan returns value p(x),
//   slope p'(x), poly_degree and the two saturation flags, one result per
//   request, in order.
// Timing:
//   A microcoded sequence runs per request: accept, load, then one Horner
//   step per coefficient below the top on the shared multiplier pair
//   (multiply, then add), then output register load. The next request is
//   taken once the item reaches the output register; the output register
//   load stalls while an earlier result there is not yet accepted.
// Reset: coefficients clear to zero, the sequencer waits for a request and
//   out_chan.valid drops. A stalled receiver holds the result in the output
//   register; one finished item may wait there while the next is computed.
module polynomial_eval_with_derivative_unit #(
  parameter int NUM_COEFFS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pev_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pev_pkg::DATA_W-1:0]    cfg_data,
  pev_in_if.sink                        in_chan,
  pev_out_if.source                     out_chan
);

  pev_pkg::uword_t     ctrl;
  pev_pkg::dp_status_t sts;

  pev_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  pev_dp #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule
